[hdl/rfk_pkg.sv]
package rfk_pkg;

  // Fixed field and register widths
  localparam int unsigned CodeW    = 8;
  localparam int unsigned KeyW     = 2;
  localparam int unsigned KindW    = 2;
  localparam int unsigned SustainW = 8;
  localparam int unsigned HoldW    = 10;
  localparam int unsigned RepeatW  = 8;
  localparam int unsigned DebW     = 4;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned MaxEvents = 3;
  localparam int unsigned CntW     = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_SUSTAIN    = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_HOLD_START = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_REPEAT     = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 8'd3;

  // Register reset values
  localparam logic [SustainW-1:0] SUSTAIN_RST    = 8'd20;
  localparam logic [HoldW-1:0]    HOLD_START_RST = 10'd100;
  localparam logic [RepeatW-1:0]  REPEAT_RST     = 8'd30;
  localparam logic [DebW-1:0]     DEBOUNCE_RST   = 4'd1;

  // Event kinds
  localparam logic [KindW-1:0] EVT_PRESS   = 2'd0;
  localparam logic [KindW-1:0] EVT_RELEASE = 2'd1;
  localparam logic [KindW-1:0] EVT_HOLD    = 2'd2;

  // Keys
  localparam logic [KeyW-1:0] KEY_UP    = 2'd0;
  localparam logic [KeyW-1:0] KEY_DOWN  = 2'd1;
  localparam logic [KeyW-1:0] KEY_POWER = 2'd2;
  localparam logic [KeyW-1:0] KEY_MODE  = 2'd3;

  typedef struct packed {
    logic            hit;
    logic [KeyW-1:0] key;
  } key_slot_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [KindW-1:0] kind;
  } event_t;

  // Events produced by one tick, in order ev[0] .. ev[cnt-1]
  typedef struct packed {
    logic [CntW-1:0]             cnt;
    event_t [MaxEvents-1:0]      ev;
  } bundle_t;

  // Map a raw remote code to a key; anything else is noise
  function automatic key_slot_t code_to_key(input logic [CodeW-1:0] code);
    key_slot_t ks;
    ks.hit = 1'b1;
    ks.key = KEY_UP;
    case (code)
      8'h04, 8'h2E: ks.key = KEY_UP;
      8'h05, 8'h4C: ks.key = KEY_DOWN;
      8'h1A, 8'h5B: ks.key = KEY_POWER;
      8'h01, 8'h3D: ks.key = KEY_MODE;
      default:      ks.hit = 1'b0;
    endcase
    return ks;
  endfunction

endpackage

[hdl/rfk_front.sv]
module rfk_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [rfk_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rfk_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            tick_i,
  input  logic                            packet_valid_i,
  input  logic [rfk_pkg::CodeW-1:0]       packet_code_i,
  output logic                            push_o,
  output rfk_pkg::bundle_t                bundle_o
);

  logic [rfk_pkg::SustainW-1:0] sustain_cfg_q;
  logic [rfk_pkg::HoldW-1:0]    hold_cfg_q;
  logic [rfk_pkg::RepeatW-1:0]  repeat_cfg_q;
  logic [rfk_pkg::DebW-1:0]     deb_cfg_q;

  logic [rfk_pkg::SustainW-1:0] sustain_q, sustain_d;
  logic [rfk_pkg::HoldW-1:0]    held_q, held_d;
  logic [rfk_pkg::RepeatW-1:0]  rtimer_q, rtimer_d;
  rfk_pkg::key_slot_t           active_q, active_d;
  logic [rfk_pkg::DebW-1:0]     hits_q, hits_d;
  rfk_pkg::key_slot_t           dkey_q, dkey_d;

  rfk_pkg::bundle_t             bundle;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sustain_cfg_q <= rfk_pkg::SUSTAIN_RST;
      hold_cfg_q    <= rfk_pkg::HOLD_START_RST;
      repeat_cfg_q  <= rfk_pkg::REPEAT_RST;
      deb_cfg_q     <= rfk_pkg::DEBOUNCE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rfk_pkg::REG_SUSTAIN:    sustain_cfg_q <= cfg_data_i[rfk_pkg::SustainW-1:0];
        rfk_pkg::REG_HOLD_START: hold_cfg_q    <= cfg_data_i[rfk_pkg::HoldW-1:0];
        rfk_pkg::REG_REPEAT:     repeat_cfg_q  <= cfg_data_i[rfk_pkg::RepeatW-1:0];
        rfk_pkg::REG_DEBOUNCE:   deb_cfg_q     <= cfg_data_i[rfk_pkg::DebW-1:0];
        default: ;
      endcase
    end
  end

  // Classify the tick and work out the next key state and its events
  always_comb begin
    rfk_pkg::key_slot_t ks;
    logic [rfk_pkg::CntW-1:0] n;
    ks         = rfk_pkg::code_to_key(packet_code_i);
    n          = '0;
    sustain_d  = sustain_q;
    held_d     = held_q;
    rtimer_d   = rtimer_q;
    active_d   = active_q;
    hits_d     = hits_q;
    dkey_d     = dkey_q;
    bundle.ev  = '0;

    if (packet_valid_i) begin
      if (ks.hit) begin
        // debounce: count repeats of the same key, restart on another
        if (dkey_q.hit && dkey_q.key == ks.key) begin
          if (hits_q < deb_cfg_q) hits_d = hits_q + 1'b1;
        end else begin
          dkey_d = ks;
          hits_d = rfk_pkg::DebW'(1);
        end
        if (hits_d >= deb_cfg_q) begin
          if (!active_q.hit) begin
            active_d = ks;
            held_d   = '0;
            rtimer_d = '0;
            bundle.ev[n] = '{key: ks.key, kind: rfk_pkg::EVT_PRESS};
            n = n + 1'b1;
          end else if (ks.key != active_q.key) begin
            bundle.ev[n] = '{key: active_q.key, kind: rfk_pkg::EVT_RELEASE};
            n = n + 1'b1;
            active_d = ks;
            held_d   = '0;
            rtimer_d = '0;
            bundle.ev[n] = '{key: ks.key, kind: rfk_pkg::EVT_PRESS};
            n = n + 1'b1;
          end
        end
        sustain_d = sustain_cfg_q;
      end else begin
        // noise clears the debounce
        hits_d = '0;
        dkey_d = '0;
      end
    end

    // Advance the held key or release it on timeout
    if (active_d.hit) begin
      if (sustain_d != '0) begin
        sustain_d = sustain_d - 1'b1;
        if (held_d < hold_cfg_q) held_d = held_d + 1'b1;
        if (held_d >= hold_cfg_q) begin
          if (rtimer_d != '1) rtimer_d = rtimer_d + 1'b1;
          if (rtimer_d >= repeat_cfg_q) begin
            rtimer_d = '0;
            bundle.ev[n] = '{key: active_d.key, kind: rfk_pkg::EVT_HOLD};
            n = n + 1'b1;
          end
        end
      end else begin
        hits_d = '0;
        dkey_d = '0;
        bundle.ev[n] = '{key: active_d.key, kind: rfk_pkg::EVT_RELEASE};
        n = n + 1'b1;
        active_d = '0;
        held_d   = '0;
      end
    end
    bundle.cnt = n;
  end

  // Key state advances once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sustain_q <= '0;
      held_q    <= '0;
      rtimer_q  <= '0;
      active_q  <= '0;
      hits_q    <= '0;
      dkey_q    <= '0;
    end else if (tick_i) begin
      sustain_q <= sustain_d;
      held_q    <= held_d;
      rtimer_q  <= rtimer_d;
      active_q  <= active_d;
      hits_q    <= hits_d;
      dkey_q    <= dkey_d;
    end
  end

  // Queue only ticks that raise events
  assign push_o   = tick_i && (bundle.cnt != '0);
  assign bundle_o = bundle;

endmodule

[hdl/rfk_queue.sv]
module rfk_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rfk_pkg::bundle_t push_data_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output rfk_pkg::bundle_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0]  LastPtr = PtrW'(Depth - 1);
  localparam logic [FillW-1:0] FullCnt = FillW'(Depth);

  rfk_pkg::bundle_t   mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0]   fill_q;

  assign full_o  = (fill_q == FullCnt);
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store requests
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      fill_q <= fill_q + 1'b1;
      else if (pop_i && !push_i) fill_q <= fill_q - 1'b1;
    end
  end

endmodule

[hdl/rfk_serialiser.sv]
module rfk_serialiser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  rfk_pkg::bundle_t            head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rfk_pkg::KeyW-1:0]    key_id_o,
  output logic [rfk_pkg::KindW-1:0]   event_kind_o,
  output logic                        last_o
);

  logic [rfk_pkg::CntW-1:0] idx_q;
  logic                     fire;
  rfk_pkg::event_t          ev;

  assign out_valid_o  = !empty_i;
  assign ev           = head_i.ev[idx_q];
  assign key_id_o     = ev.key;
  assign event_kind_o = ev.kind;
  assign last_o       = (idx_q == head_i.cnt - 1'b1);
  assign fire         = out_valid_o && out_ready_i;
  assign pop_o        = fire && last_o;

  // Step through the events of the head request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= last_o ? '0 : idx_q + 1'b1;
    end
  end

endmodule

[hdl/rf_key_press_hold_engine.sv]
// Remote key engine: each input request is one 10 ms tick with an optional
// received code; the block debounces the code, tracks the active key and
// emits press, release and hold-repeat events, up to three per tick, with
// last set on the final event of a tick. A tick is taken every cycle while
// the event queue (QueueDepth ticks deep) has room; ticks that raise no event
// use no queue space. The output side delivers one event per cycle while
// out_ready_i is high, so a tick's events, at most three, take the result
// channel one after another; the output serialiser sets the sustained rate.
// Registers: 0 sustain ticks, 1 hold start ticks, 2 repeat ticks, 3 debounce
// count; a write is always taken and unknown indexes are ignored.
module rf_key_press_hold_engine #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rfk_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rfk_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            packet_valid_i,
  input  logic [rfk_pkg::CodeW-1:0]       packet_code_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rfk_pkg::KeyW-1:0]        key_id_o,
  output logic [rfk_pkg::KindW-1:0]       event_kind_o,
  output logic                            last_o
);

  logic             full, empty, push, pop, tick;
  rfk_pkg::bundle_t push_data, head;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full;
  assign tick        = in_valid_i && in_ready_o;

  rfk_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .tick_i         (tick),
    .packet_valid_i (packet_valid_i),
    .packet_code_i  (packet_code_i),
    .push_o         (push),
    .bundle_o       (push_data)
  );

  rfk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .empty_o     (empty),
    .pop_i       (pop),
    .head_o      (head)
  );

  rfk_serialiser u_serialiser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .key_id_o     (key_id_o),
    .event_kind_o (event_kind_o),
    .last_o       (last_o)
  );

endmodule
